// ----- hdl/fpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsa_pkg: frame pool segment allocator package
// shared widths, codes, payload structs and the sequencer state type
// ----------------------------------------------------------------------------
package fpsa_pkg;

  // default geometry of the pool
  localparam int unsigned FRAME_COUNT_DEF  = 4096;
  localparam int unsigned FRAME_BYTES_DEF  = 4096;
  localparam int unsigned MAX_SEGMENTS_DEF = 4;

  // field widths
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned SEG_LEN_W   = 13;
  localparam int unsigned SEG_INDEX_W = 4;
  localparam int unsigned FREE_CNT_W  = 13;
  localparam int unsigned HEADROOM_W  = 12;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  // largest segment a frame can take
  localparam logic [SEG_LEN_W-1:0] SEG_MAX = 13'd4096;

  // request types
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_FRAME = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN  = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADROOM    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEG_BYTES   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PKT_LEN = 2'd2;

  // configuration reset values
  localparam logic [HEADROOM_W-1:0] HEADROOM_RST    = 12'd256;
  localparam logic [SEG_LEN_W-1:0]  SEG_BYTES_RST   = 13'd3840;
  localparam logic [LEN_W-1:0]      MAX_PKT_LEN_RST = 16'd9018;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [LEN_W-1:0]  packet_length;
    logic [ADDR_W-1:0] frame_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [ADDR_W-1:0]      seg_addr;
    logic [SEG_LEN_W-1:0]   seg_len;
    logic [SEG_INDEX_W-1:0] seg_index;
    logic [LEN_W-1:0]       pkt_total;
    logic [FREE_CNT_W-1:0]  free_count;
    logic                   last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_READ,
    ST_EMIT,
    ST_REPLY
  } state_e;

endpackage

// ----- hdl/frame_pool_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// frame_pool_segment_allocator: packet buffer manager with a ring free list
// hands out fixed-size frames singly or as segments of a stored packet, and
// takes freed frames back onto the tail of the list
// ----------------------------------------------------------------------------
// order of work: a free goes to its reply; an allocate reads the list and emits its
//   frame, or replies when the list is empty; a store runs its count steps, then a
//   list read and a result per segment, or a reply when rejected; stalled results wait
// throughput: one item at a time; in_ready_o is high only when the sequencer
//   is idle, all work goes through the shared subtract/compare unit and one list read
// reset: list full with entry i holding frame i; a fill count marks written entries
// ----------------------------------------------------------------------------
module frame_pool_segment_allocator #(
  parameter int unsigned FRAME_COUNT  = fpsa_pkg::FRAME_COUNT_DEF,
  parameter int unsigned FRAME_BYTES  = fpsa_pkg::FRAME_BYTES_DEF, // power of two
  parameter int unsigned MAX_SEGMENTS = fpsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fpsa_pkg::req_t                      in_data_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fpsa_pkg::rsp_t                      out_data_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fpsa_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [fpsa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // geometry derived from the parameters
  localparam int unsigned IW   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1; // list index
  localparam int unsigned CW   = $clog2(FRAME_COUNT + 1);                     // free count
  localparam int unsigned FBW  = $clog2(FRAME_BYTES);                         // byte offset
  localparam int unsigned FNW  = fpsa_pkg::ADDR_W - FBW;                      // frame number
  localparam int unsigned NW   = $clog2(MAX_SEGMENTS + 1);                    // segment count
  localparam int unsigned CMPW = (CW > NW) ? CW : NW;

  localparam logic [IW-1:0] LAST_IDX = IW'(FRAME_COUNT - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FRAME_COUNT);
  localparam logic [NW-1:0] NSEG_MAX = NW'(MAX_SEGMENTS);

  // sequencer and pointers
  fpsa_pkg::state_e state_q, state_d;
  logic [IW-1:0]    take_idx_q, give_idx_q;
  logic [CW-1:0]    count_q;      // free frames in the list
  logic [CW-1:0]    fill_q;       // entries written since reset, saturating

  // configuration
  logic [fpsa_pkg::HEADROOM_W-1:0] headroom_q;
  logic [fpsa_pkg::SEG_LEN_W-1:0]  seg_bytes_q;
  logic [fpsa_pkg::LEN_W-1:0]      max_len_q;

  // item context
  logic [1:0]                       req_q;
  logic [fpsa_pkg::LEN_W-1:0]       len_q;
  logic [fpsa_pkg::LEN_W-1:0]       rem_q;
  logic [NW-1:0]                    nseg_q;
  logic [fpsa_pkg::SEG_INDEX_W-1:0] idx_q;
  logic [1:0]                       reply_status_q;

  // free list memory and its registered read
  logic [FNW-1:0] free_list_q [FRAME_COUNT];
  logic [FNW-1:0] rd_data_q;
  logic           rd_fresh_q;     // entry never written, reads as its own frame

  // result register
  logic           out_valid_q;
  fpsa_pkg::rsp_t out_q;

  // control decoded from the state
  logic accept;
  logic out_free;
  logic mem_we;
  logic rd_en;
  logic load_seg;
  logic load_reply;

  // shared subtract/compare unit and helpers
  logic [fpsa_pkg::SEG_LEN_W-1:0] seg_eff;
  logic                           rem_gt;
  logic [fpsa_pkg::LEN_W-1:0]     rem_diff;
  logic [NW-1:0]                  nseg_inc;
  logic                           frames_ok;
  logic                           bad_len;
  logic                           list_full;
  logic [FNW-1:0]                 frame_num;
  logic [fpsa_pkg::ADDR_W-1:0]    seg_addr;
  logic [IW-1:0]                  take_idx_nx, give_idx_nx;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == fpsa_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // segment size clamped to SEG_MAX, zero taken as one byte
  always_comb begin
    if (seg_bytes_q == '0) begin
      seg_eff = fpsa_pkg::SEG_LEN_W'(1);
    end else if (seg_bytes_q > fpsa_pkg::SEG_MAX) begin
      seg_eff = fpsa_pkg::SEG_MAX;
    end else begin
      seg_eff = seg_bytes_q;
    end
  end

  // one compare and subtract, used by the count steps and the segment steps
  assign rem_gt    = rem_q > fpsa_pkg::LEN_W'(seg_eff);
  assign rem_diff  = rem_q - fpsa_pkg::LEN_W'(seg_eff);
  assign nseg_inc  = NW'(nseg_q + 1'b1);
  assign frames_ok = CMPW'(count_q) >= CMPW'(nseg_inc);

  assign bad_len   = (in_data_i.packet_length == '0) ||
                     (in_data_i.packet_length > max_len_q);
  assign list_full = (count_q == FULL_CNT);

  // frame base plus headroom, wrapping in the address width
  assign frame_num = rd_fresh_q ? FNW'(take_idx_q) : rd_data_q;
  assign seg_addr  = {frame_num, {FBW{1'b0}}} + fpsa_pkg::ADDR_W'(headroom_q);

  // ring index steps, wrapping at the list depth
  assign take_idx_nx = (take_idx_q == LAST_IDX) ? '0 : IW'(take_idx_q + 1'b1);
  assign give_idx_nx = (give_idx_q == LAST_IDX) ? '0 : IW'(give_idx_q + 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fpsa_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data_i.req_type)
            fpsa_pkg::REQ_ALLOC: begin
              state_d = (count_q == '0) ? fpsa_pkg::ST_REPLY : fpsa_pkg::ST_READ;
            end
            fpsa_pkg::REQ_STORE: begin
              state_d = bad_len ? fpsa_pkg::ST_REPLY : fpsa_pkg::ST_COUNT;
            end
            fpsa_pkg::REQ_FREE: begin
              state_d = fpsa_pkg::ST_REPLY;
            end
            default: begin
              state_d = fpsa_pkg::ST_IDLE;   // unused request code, dropped
            end
          endcase
        end
      end
      fpsa_pkg::ST_COUNT: begin
        if (!rem_gt) begin
          state_d = frames_ok ? fpsa_pkg::ST_READ : fpsa_pkg::ST_REPLY;
        end else if (nseg_inc == NSEG_MAX) begin
          state_d = fpsa_pkg::ST_REPLY;
        end
      end
      fpsa_pkg::ST_READ: begin
        state_d = fpsa_pkg::ST_EMIT;
      end
      fpsa_pkg::ST_EMIT: begin
        if (out_free) begin
          if (req_q == fpsa_pkg::REQ_ALLOC || !rem_gt) begin
            state_d = fpsa_pkg::ST_IDLE;
          end else begin
            state_d = fpsa_pkg::ST_READ;
          end
        end
      end
      fpsa_pkg::ST_REPLY: begin
        if (out_free) begin
          state_d = fpsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpsa_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    mem_we     = accept && (in_data_i.req_type == fpsa_pkg::REQ_FREE) && !list_full;
    rd_en      = (state_q == fpsa_pkg::ST_READ);
    load_seg   = (state_q == fpsa_pkg::ST_EMIT) && out_free;
    load_reply = (state_q == fpsa_pkg::ST_REPLY) && out_free;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpsa_pkg::ST_IDLE;
      take_idx_q  <= '0;
      give_idx_q  <= '0;
      count_q     <= FULL_CNT;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      headroom_q  <= fpsa_pkg::HEADROOM_RST;
      seg_bytes_q <= fpsa_pkg::SEG_BYTES_RST;
      max_len_q   <= fpsa_pkg::MAX_PKT_LEN_RST;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          fpsa_pkg::CFG_HEADROOM:    headroom_q  <= cfg_data_i[fpsa_pkg::HEADROOM_W-1:0];
          fpsa_pkg::CFG_SEG_BYTES:   seg_bytes_q <= cfg_data_i[fpsa_pkg::SEG_LEN_W-1:0];
          fpsa_pkg::CFG_MAX_PKT_LEN: max_len_q   <= cfg_data_i;
          default: ;                                      // no register there
        endcase
      end

      // a freed frame goes onto the tail
      if (mem_we) begin
        give_idx_q <= give_idx_nx;
        count_q    <= CW'(count_q + 1'b1);
        if (fill_q != FULL_CNT) begin
          fill_q <= CW'(fill_q + 1'b1);
        end
      end

      // a frame leaves the head as its result is loaded
      if (load_seg) begin
        take_idx_q <= take_idx_nx;
        count_q    <= CW'(count_q - 1'b1);
      end

      if (load_seg || load_reply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item context and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_data_i.req_type;
      len_q  <= in_data_i.packet_length;
      rem_q  <= in_data_i.packet_length;
      nseg_q <= '0;
      idx_q  <= '0;
      case (in_data_i.req_type)
        fpsa_pkg::REQ_ALLOC: reply_status_q <= fpsa_pkg::STATUS_NO_FRAME;
        fpsa_pkg::REQ_STORE: reply_status_q <= fpsa_pkg::STATUS_BAD_LEN;
        default: begin
          reply_status_q <= list_full ? fpsa_pkg::STATUS_OVERFLOW : fpsa_pkg::STATUS_OK;
        end
      endcase
    end

    // count steps: find the segment count, give up past the limit
    if (state_q == fpsa_pkg::ST_COUNT) begin
      if (!rem_gt) begin
        nseg_q         <= nseg_inc;
        rem_q          <= len_q;
        reply_status_q <= fpsa_pkg::STATUS_NO_FRAME;
      end else begin
        nseg_q         <= nseg_inc;
        rem_q          <= rem_diff;
        reply_status_q <= fpsa_pkg::STATUS_BAD_LEN;
      end
    end

    if (rd_en) begin
      rd_data_q  <= free_list_q[take_idx_q];
      rd_fresh_q <= CW'(take_idx_q) >= fill_q;
    end

    if (load_seg) begin
      rem_q <= rem_diff;
      idx_q <= fpsa_pkg::SEG_INDEX_W'(idx_q + 1'b1);
      out_q.status     <= fpsa_pkg::STATUS_OK;
      out_q.seg_addr   <= seg_addr;
      out_q.free_count <= fpsa_pkg::FREE_CNT_W'(CW'(count_q - 1'b1));
      if (req_q == fpsa_pkg::REQ_ALLOC) begin
        out_q.seg_len   <= '0;
        out_q.seg_index <= '0;
        out_q.pkt_total <= '0;
        out_q.last      <= 1'b1;
      end else begin
        out_q.seg_len   <= rem_gt ? seg_eff : fpsa_pkg::SEG_LEN_W'(rem_q);
        out_q.seg_index <= idx_q;
        out_q.pkt_total <= len_q;
        out_q.last      <= !rem_gt;
      end
    end else if (load_reply) begin
      out_q.status     <= reply_status_q;
      out_q.seg_addr   <= '0;
      out_q.seg_len    <= '0;
      out_q.seg_index  <= '0;
      out_q.pkt_total  <= (req_q == fpsa_pkg::REQ_STORE) ? len_q : '0;
      out_q.free_count <= fpsa_pkg::FREE_CNT_W'(count_q);
      out_q.last       <= 1'b1;
    end
  end

  // free list memory, one write and one read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      free_list_q[give_idx_q] <= in_data_i.frame_addr[fpsa_pkg::ADDR_W-1:FBW];
    end
  end

  // free count never exceeds the pool
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("free count beyond pool size");

  // fill count never exceeds the list depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_CNT)
    else $error("fill count beyond list depth");

  // a frame is only handed out when the list holds one
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpsa_pkg::ST_EMIT) |-> (count_q != '0))
    else $error("segment emitted from empty list");

  // each handed-out frame lowers the free count by one
  a_take_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_seg |=> (count_q == CW'($past(count_q) - 1'b1)))
    else $error("free count not decremented on take");

  // a result is only loaded into an empty or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_seg || load_reply) |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");

endmodule
